### rtl/core/sdd_pkg.sv
package sdd_pkg;

	// default ring size
	localparam int unsigned HISTORY_DEPTH = 16;

	// own talker id registers held in the block, and how many may filter
	localparam int unsigned OWN_REGS    = 4;
	localparam int unsigned OWN_SOURCES = 4;

	// field widths
	localparam int unsigned ID_W    = 64;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned VLAN_W  = 12;
	localparam int unsigned MAC_W   = 48;
	localparam int unsigned OFF_W   = 16;
	localparam int unsigned CNT_W   = 3;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 64;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID_A  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID_B  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID_C  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID_D  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_COUNT = 3'd4;

	// request opcodes
	localparam logic FUNC_ADD  = 1'b0;
	localparam logic FUNC_POLL = 1'b1;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [VLAN_W-1:0] vlan;
		logic [MAC_W-1:0]  mac;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OWN,
		ST_SCAN,
		ST_SCAN_LAST,
		ST_WRITE,
		ST_POLL_RD,
		ST_POLL_DATA
	} state_t;

endpackage

### rtl/core/sdd_if.sv
interface sdd_req_if;
	logic                           valid;
	logic                           ready;
	logic                           func;
	logic [sdd_pkg::WORD_W-1:0]     stream_id_high;
	logic [sdd_pkg::WORD_W-1:0]     stream_id_low;
	logic [sdd_pkg::VLAN_W-1:0]     vlan_in;
	logic [sdd_pkg::MAC_W-1:0]      mac_in;
	logic                           mac_present;
	logic signed [sdd_pkg::OFF_W-1:0] mac_offset;

	modport source (
		output valid, func, stream_id_high, stream_id_low, vlan_in, mac_in,
			mac_present, mac_offset,
		input  ready
	);
	modport sink (
		input  valid, func, stream_id_high, stream_id_low, vlan_in, mac_in,
			mac_present, mac_offset,
		output ready
	);
endinterface

interface sdd_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       available;
	logic [sdd_pkg::WORD_W-1:0] out_id_high;
	logic [sdd_pkg::WORD_W-1:0] out_id_low;
	logic [sdd_pkg::VLAN_W-1:0] vlan_out;
	logic [sdd_pkg::MAC_W-1:0]  mac_out;

	modport source (
		output valid, available, out_id_high, out_id_low, vlan_out, mac_out,
		input  ready
	);
	modport sink (
		input  valid, available, out_id_high, out_id_low, vlan_out, mac_out,
		output ready
	);
endinterface

### rtl/core/sdd_ram.sv
module sdd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/core/stream_discovery_dedup_fifo.sv
// stream discovery history with duplicate suppression
//
// req channel (valid/ready): func = add carries a detected stream (id, vlan,
// address, offset); func = poll asks for the oldest stream not yet taken.
// rsp channel (valid/ready): one beat per poll, none per add; available = 0
// with an all-zero payload when the history holds nothing.
// cfg port: write enable, index and data; registers 0..3 are own talker ids,
// register 4 the number of them used for filtering. write only while idle.
//
// an add walks the own ids in use one per cycle on a single 64-bit comparator,
// then scans every history slot through the ram's registered read port, one
// slot per cycle, on the same comparator, and ends early when it finds a
// duplicate or an own id. a poll reads the oldest slot in ST_POLL_RD and loads
// the output register in ST_POLL_DATA; an empty history skips the read.
// req is ready only in idle.
// reset clears the pointers, the per-slot valid bits (an unwritten slot reads
// as id zero) and the config registers; no clearing pass is needed.
// a stalled rsp holds its beat; a poll waiting behind it holds in the
// sequencer until the output register frees up.
module stream_discovery_dedup_fifo #(
	parameter int unsigned HISTORY_DEPTH = sdd_pkg::HISTORY_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sdd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sdd_pkg::CFG_DATA_W-1:0]  cfg_data,
	sdd_req_if.sink                         req,
	sdd_rsp_if.source                       rsp
);

	localparam int unsigned AW = $clog2(HISTORY_DEPTH);
	localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);
	localparam logic [sdd_pkg::CNT_W-1:0] OWN_MAX = sdd_pkg::CNT_W'(sdd_pkg::OWN_SOURCES);

	sdd_pkg::state_t state_q, state_d;

	// config
	logic [sdd_pkg::ID_W-1:0]  own_id_q [sdd_pkg::OWN_REGS];
	logic [sdd_pkg::CNT_W-1:0] own_cnt_q;

	// ring control
	logic [AW-1:0]            rd_slot_q, wr_slot_q;
	logic [HISTORY_DEPTH-1:0] valid_q;

	// sequencer
	logic [sdd_pkg::CNT_W-1:0] own_idx_q;
	logic [AW-1:0]             scan_q;
	logic                      pend_q, pend_vld_q;

	// latched request
	logic [sdd_pkg::ID_W-1:0]   id_q;
	logic [sdd_pkg::VLAN_W-1:0] vlan_q;
	logic [sdd_pkg::MAC_W-1:0]  mac_q;
	logic                       empty_q;

	// output register
	logic                        out_valid_q;
	logic                        out_avail_q;
	sdd_pkg::entry_t             out_entry_q;

	// ram
	logic            ram_wr_en, ram_rd_en;
	logic [AW-1:0]   ram_rd_addr;
	sdd_pkg::entry_t ram_wr_data, ram_rd_data;

	// control
	logic                      req_fire, out_free, out_load;
	logic [sdd_pkg::CNT_W-1:0] own_limit;
	logic                      own_done;
	logic [sdd_pkg::ID_W-1:0]  cmp_b;
	logic                      hit;
	logic [AW-1:0]             wr_next, rd_next;
	logic [sdd_pkg::MAC_W-1:0] mac_sum;

	sdd_ram #(
		.WIDTH ($bits(sdd_pkg::entry_t)),
		.DEPTH (HISTORY_DEPTH)
	) u_hist (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (wr_slot_q),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	assign req_fire  = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign own_limit = (own_cnt_q > OWN_MAX) ? OWN_MAX : own_cnt_q;
	assign own_done  = (own_idx_q >= own_limit);
	assign wr_next   = (wr_slot_q == LAST_SLOT) ? '0 : wr_slot_q + AW'(1);
	assign rd_next   = (rd_slot_q == LAST_SLOT) ? '0 : rd_slot_q + AW'(1);

	// sign-extended offset, wraps modulo 2^48
	assign mac_sum = req.mac_in
		+ {{(sdd_pkg::MAC_W - sdd_pkg::OFF_W){req.mac_offset[sdd_pkg::OFF_W-1]}},
		req.mac_offset};

	// shared comparator: own ids first, then the history scan
	// a slot never written reads as id zero
	always_comb begin
		if (state_q == sdd_pkg::ST_OWN) begin
			cmp_b = own_id_q[own_idx_q[1:0]];
		end else if (pend_vld_q) begin
			cmp_b = ram_rd_data.id;
		end else begin
			cmp_b = '0;
		end
	end
	assign hit = (id_q == cmp_b);

	assign ram_wr_data.id   = id_q;
	assign ram_wr_data.vlan = vlan_q;
	assign ram_wr_data.mac  = mac_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sdd_pkg::ST_IDLE: begin
				if (req_fire) begin
					if (req.func == sdd_pkg::FUNC_POLL) begin
						state_d = (rd_slot_q == wr_slot_q) ? sdd_pkg::ST_POLL_DATA
							: sdd_pkg::ST_POLL_RD;
					end else begin
						state_d = sdd_pkg::ST_OWN;
					end
				end
			end
			sdd_pkg::ST_OWN: begin
				if (own_done) begin
					state_d = sdd_pkg::ST_SCAN;
				end else if (hit) begin
					state_d = sdd_pkg::ST_IDLE;
				end
			end
			sdd_pkg::ST_SCAN: begin
				if (pend_q && hit) begin
					state_d = sdd_pkg::ST_IDLE;
				end else if (scan_q == LAST_SLOT) begin
					state_d = sdd_pkg::ST_SCAN_LAST;
				end
			end
			sdd_pkg::ST_SCAN_LAST: begin
				state_d = hit ? sdd_pkg::ST_IDLE : sdd_pkg::ST_WRITE;
			end
			sdd_pkg::ST_WRITE: begin
				state_d = sdd_pkg::ST_IDLE;
			end
			sdd_pkg::ST_POLL_RD: begin
				state_d = sdd_pkg::ST_POLL_DATA;
			end
			sdd_pkg::ST_POLL_DATA: begin
				if (out_free) begin
					state_d = sdd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sdd_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		req.ready   = 1'b0;
		ram_rd_en   = 1'b0;
		ram_rd_addr = rd_slot_q;
		ram_wr_en   = 1'b0;
		out_load    = 1'b0;
		case (state_q)
			sdd_pkg::ST_IDLE: begin
				req.ready = 1'b1;
			end
			sdd_pkg::ST_SCAN: begin
				ram_rd_en   = 1'b1;
				ram_rd_addr = scan_q;
			end
			sdd_pkg::ST_WRITE: begin
				ram_wr_en = 1'b1;
			end
			sdd_pkg::ST_POLL_RD: begin
				ram_rd_en = 1'b1;
			end
			sdd_pkg::ST_POLL_DATA: begin
				out_load = out_free;
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sdd_pkg::ST_IDLE;
			own_id_q    <= '{default: '0};
			own_cnt_q   <= '0;
			rd_slot_q   <= '0;
			wr_slot_q   <= '0;
			valid_q     <= '0;
			own_idx_q   <= '0;
			scan_q      <= '0;
			pend_q      <= 1'b0;
			pend_vld_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				case (cfg_index)
					sdd_pkg::CFG_OWN_ID_A:  own_id_q[0] <= cfg_data;
					sdd_pkg::CFG_OWN_ID_B:  own_id_q[1] <= cfg_data;
					sdd_pkg::CFG_OWN_ID_C:  own_id_q[2] <= cfg_data;
					sdd_pkg::CFG_OWN_ID_D:  own_id_q[3] <= cfg_data;
					sdd_pkg::CFG_OWN_COUNT: own_cnt_q <= cfg_data[sdd_pkg::CNT_W-1:0];
					default: ;
				endcase
			end

			if (state_q == sdd_pkg::ST_IDLE) begin
				own_idx_q <= '0;
			end else if (state_q == sdd_pkg::ST_OWN) begin
				own_idx_q <= own_idx_q + sdd_pkg::CNT_W'(1);
			end

			// scan issues one read a cycle, compares the previous one
			if (state_q == sdd_pkg::ST_SCAN) begin
				scan_q     <= scan_q + AW'(1);
				pend_q     <= 1'b1;
				pend_vld_q <= valid_q[scan_q];
			end else begin
				scan_q     <= '0;
				pend_q     <= 1'b0;
				if (state_q != sdd_pkg::ST_SCAN_LAST) begin
					pend_vld_q <= 1'b0;
				end
			end

			if (ram_wr_en) begin
				valid_q[wr_slot_q] <= 1'b1;
				wr_slot_q          <= wr_next;
				// ring full: drop the oldest
				if (wr_next == rd_slot_q) begin
					rd_slot_q <= rd_next;
				end
			end

			if (out_load && !empty_q) begin
				rd_slot_q <= rd_next;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (req_fire) begin
			id_q    <= {req.stream_id_high, req.stream_id_low};
			vlan_q  <= req.vlan_in;
			mac_q   <= req.mac_present ? mac_sum : '0;
			empty_q <= (rd_slot_q == wr_slot_q);
		end
		if (out_load) begin
			out_avail_q <= !empty_q;
			out_entry_q <= empty_q ? '0 : ram_rd_data;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.available   = out_avail_q;
	assign rsp.out_id_high = out_entry_q.id[sdd_pkg::ID_W-1:sdd_pkg::WORD_W];
	assign rsp.out_id_low  = out_entry_q.id[sdd_pkg::WORD_W-1:0];
	assign rsp.vlan_out    = out_entry_q.vlan;
	assign rsp.mac_out     = out_entry_q.mac;

`ifndef SYNTHESIS
	// a rsp beat only ever starts from a finished poll
	a_rsp_from_poll: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == sdd_pkg::ST_POLL_DATA))
		else $error("rsp beat without a poll");

	// an empty poll carries an all-zero payload
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.available) |-> (rsp.out_id_high == '0 && rsp.out_id_low == '0
			&& rsp.vlan_out == '0 && rsp.mac_out == '0))
		else $error("empty poll with nonzero payload");

	// the write pointer moves only on a history write
	a_wr_only_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_slot_q != $past(wr_slot_q)) |-> $past(state_q == sdd_pkg::ST_WRITE))
		else $error("write pointer moved outside a write");

	// after a write the ring is never seen as empty
	a_not_empty_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sdd_pkg::ST_WRITE) |=> (rd_slot_q != wr_slot_q))
		else $error("ring empty right after a write");
`endif

endmodule

### test/stream_discovery_dedup_fifo_test.sv
`timescale 1ns / 1ps

module stream_discovery_dedup_fifo_test;
	import sdd_pkg::*;

	localparam int unsigned HIST = sdd_pkg::HISTORY_DEPTH;
	localparam int unsigned POOL = 24;
	localparam int unsigned PHASES = 6;
	localparam int unsigned ITEMS_PER_PHASE = 305;
	// an add walks own ids plus every slot, so give it well over that before idle
	localparam int unsigned SETTLE = 40;

	// one request beat as the predictor sees it
	typedef struct packed {
		logic        func;
		logic [63:0] id;
		logic [11:0] vlan;
		logic [47:0] mac;
		logic        present;
		logic [15:0] offset;
	} disc_req_t;

	// one poll answer
	typedef struct packed {
		logic        avail;
		logic [63:0] id;
		logic [11:0] vlan;
		logic [47:0] mac;
	} popped_t;

	// directed stimulus: the answer is typed in only where it is obvious
	typedef struct {
		disc_req_t rq;
		bit        typed;
		popped_t   want;
	} dir_row_t;

	localparam popped_t NOTHING = '0;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sdd_req_if req_ch ();
	sdd_rsp_if rsp_ch ();

	stream_discovery_dedup_fifo dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of the register file and the history ring
	logic [63:0] own_id [4];
	logic [2:0]  own_count;
	logic [63:0] ring_id [HIST];
	logic [11:0] ring_vlan [HIST];
	logic [47:0] ring_mac [HIST];
	int unsigned rd_slot;
	int unsigned wr_slot;

	// answers still owed by the block, oldest first
	popped_t pending_polls[$];
	dir_row_t dir_rows[$];
	logic [63:0] id_pool [POOL];

	int mismatches;
	int rsp_hold;
	bit calm;

	// tallies for the closing summary
	int n_sent;
	int n_stored;
	int n_own_drop;
	int n_dup_drop;
	int n_popped;
	int n_empty;

	function automatic int unsigned bump(int unsigned s);
		return (s + 1 == HIST) ? 0 : s + 1;
	endfunction

	// gap length for either side: mostly none, some short, a few long
	function automatic int pick_gap();
		int unsigned roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// history update for one accepted beat; a poll yields one answer
	task automatic track_request(input disc_req_t r, output bit answered, output popped_t p);
		int unsigned lim;
		int unsigned nw;
		int k;
		bit own_hit;
		bit seen;
		logic [47:0] addr;
		answered = 1'b0;
		p = NOTHING;
		if (r.func == FUNC_ADD) begin
			// count above the number of own sources saturates
			lim = own_count;
			if (lim > OWN_SOURCES)
				lim = OWN_SOURCES;
			if (lim > 4)
				lim = 4;
			own_hit = 1'b0;
			for (k = 0; k < int'(lim); k++)
				if (own_id[k] == r.id)
					own_hit = 1'b1;
			// stale and never-written slots count too, so id zero never gets in
			seen = 1'b0;
			for (k = 0; k < int'(HIST); k++)
				if (ring_id[k] == r.id)
					seen = 1'b1;
			if (own_hit) begin
				n_own_drop++;
			end else if (seen) begin
				n_dup_drop++;
			end else begin
				nw = bump(wr_slot);
				// ring full: the oldest live entry is lost
				if (nw == rd_slot)
					rd_slot = bump(rd_slot);
				addr = r.present ? r.mac + {{32{r.offset[15]}}, r.offset} : 48'h0;
				ring_id[wr_slot] = r.id;
				ring_vlan[wr_slot] = r.vlan;
				ring_mac[wr_slot] = addr;
				wr_slot = nw;
				n_stored++;
			end
		end else begin
			answered = 1'b1;
			if (rd_slot != wr_slot) begin
				p = '{1'b1, ring_id[rd_slot], ring_vlan[rd_slot], ring_mac[rd_slot]};
				rd_slot = bump(rd_slot);
				n_popped++;
			end else begin
				n_empty++;
			end
		end
	endtask

	function automatic disc_req_t mk(logic f, logic [63:0] id, logic [11:0] v, logic [47:0] m,
		logic pr, logic [15:0] o);
		return '{f, id, v, m, pr, o};
	endfunction

	function automatic void add_row(disc_req_t rq, bit typed, popped_t want);
		dir_row_t row;
		row.rq = rq;
		row.typed = typed;
		row.want = want;
		dir_rows.push_back(row);
	endfunction

	// random beat: ids drawn so that repeats, own ids and stale slots show up often
	function automatic disc_req_t roll_request();
		disc_req_t r;
		int unsigned pick;
		r.func = ($urandom_range(0, 99) < 40) ? FUNC_POLL : FUNC_ADD;
		pick = $urandom_range(0, 99);
		if (pick < 35)
			r.id = {$urandom, $urandom};
		else if (pick < 75)
			r.id = id_pool[$urandom_range(0, POOL - 1)];
		else if (pick < 85)
			r.id = own_id[$urandom_range(0, 3)];
		else if (pick < 90)
			r.id = 64'h0;
		else
			r.id = ring_id[$urandom_range(0, HIST - 1)];
		r.vlan = 12'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 8)
			r.mac = 48'hffff_ffff_ffff;
		else if (pick < 16)
			r.mac = 48'h0;
		else if (pick < 26)
			r.mac = 48'hffff_ffff_ff00 | 48'($urandom_range(0, 255));
		else
			r.mac = 48'({$urandom, $urandom});
		r.present = ($urandom_range(0, 99) < 75);
		pick = $urandom_range(0, 99);
		if (pick < 10)
			r.offset = 16'h8000;
		else if (pick < 20)
			r.offset = 16'h7fff;
		else if (pick < 25)
			r.offset = 16'hffff;
		else
			r.offset = 16'($urandom);
		return r;
	endfunction

	// register write, mirrored into the predictor at once since the block is idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		case (idx)
			CFG_OWN_ID_A: own_id[0] = val;
			CFG_OWN_ID_B: own_id[1] = val;
			CFG_OWN_ID_C: own_id[2] = val;
			CFG_OWN_ID_D: own_id[3] = val;
			CFG_OWN_COUNT: own_count = val[2:0];
			default: ;
		endcase
	endtask

	task automatic load_regs(input logic [63:0] a, input logic [63:0] b, input logic [63:0] c,
		input logic [63:0] d, input logic [2:0] cnt);
		write_reg(CFG_OWN_ID_A, a);
		write_reg(CFG_OWN_ID_B, b);
		write_reg(CFG_OWN_ID_C, c);
		write_reg(CFG_OWN_ID_D, d);
		write_reg(CFG_OWN_COUNT, {61'h0, cnt});
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// one request beat: optional gap, then hold until accepted, then predict
	task automatic send_req(input disc_req_t r, input bit typed, input popped_t want);
		int gap;
		bit answered;
		popped_t p;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			req_ch.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid = 1'b1;
		req_ch.func = r.func;
		req_ch.stream_id_high = r.id[63:32];
		req_ch.stream_id_low = r.id[31:0];
		req_ch.vlan_in = r.vlan;
		req_ch.mac_in = r.mac;
		req_ch.mac_present = r.present;
		req_ch.mac_offset = r.offset;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		n_sent++;
		track_request(r, answered, p);
		if (answered)
			pending_polls.push_back(typed ? want : p);
	endtask

	// let every owed answer arrive, then give any add in flight time to finish
	task automatic drain(input int settle);
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (pending_polls.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %h, got %h", $time, what, want, got);
		end
	endtask

	// response side: random stalls on ready
	initial begin
		rsp_ch.ready = 1'b0;
		rsp_hold = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rsp_hold > 0) begin
				rsp_ch.ready = 1'b0;
				rsp_hold--;
			end else begin
				rsp_ch.ready = 1'b1;
				rsp_hold = pick_gap();
			end
		end
	end

	// every accepted answer against the oldest one owed
	always @(posedge clk) begin
		popped_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_polls.size() == 0) begin
				mismatches++;
				$display("%0t: answer beat with none owed (available %b id %h_%h)", $time,
					rsp_ch.available, rsp_ch.out_id_high, rsp_ch.out_id_low);
			end else begin
				want = pending_polls.pop_front();
				check_field("available", 64'(want.avail), 64'(rsp_ch.available));
				check_field("out_id_high", 64'(want.id[63:32]), 64'(rsp_ch.out_id_high));
				check_field("out_id_low", 64'(want.id[31:0]), 64'(rsp_ch.out_id_low));
				check_field("vlan_out", 64'(want.vlan), 64'(rsp_ch.vlan_out));
				check_field("mac_out", 64'(want.mac), 64'(rsp_ch.mac_out));
			end
		end
	end

	// generous cap on the whole run
	initial begin
		#15_000_000;
		$display("stream_discovery_dedup_fifo verification failed");
		$finish;
	end

	initial begin
		int ph;
		int k;
		dir_row_t row;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_ADD;
		req_ch.stream_id_high = '0;
		req_ch.stream_id_low = '0;
		req_ch.vlan_in = '0;
		req_ch.mac_in = '0;
		req_ch.mac_present = 1'b0;
		req_ch.mac_offset = '0;
		mismatches = 0;
		calm = 1'b0;
		n_sent = 0;
		n_stored = 0;
		n_own_drop = 0;
		n_dup_drop = 0;
		n_popped = 0;
		n_empty = 0;
		for (k = 0; k < 4; k++)
			own_id[k] = 64'h0;
		own_count = 3'd0;
		for (k = 0; k < int'(HIST); k++) begin
			ring_id[k] = 64'h0;
			ring_vlan[k] = 12'h0;
			ring_mac[k] = 48'h0;
		end
		rd_slot = 0;
		wr_slot = 0;
		for (k = 0; k < int'(POOL); k++)
			id_pool[k] = {$urandom, $urandom};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part: one own id filtering
		load_regs(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
			64'h8000_0000_0000_0001, 64'h0000_0001_0000_0000, 3'd1);

		// poll right after reset finds nothing
		add_row(mk(FUNC_POLL, 64'h0, 12'h0, 48'h0, 1'b0, 16'h0), 1'b1, NOTHING);
		// id zero always hits a cleared slot
		add_row(mk(FUNC_ADD, 64'h0, 12'h005, 48'h1, 1'b1, 16'h0), 1'b0, NOTHING);
		add_row(mk(FUNC_POLL, 64'h0, 12'h0, 48'h0, 1'b0, 16'h0), 1'b1, NOTHING);
		// all-ones address plus one wraps to zero
		add_row(mk(FUNC_ADD, 64'hffff_ffff_ffff_ffff, 12'hfff, 48'hffff_ffff_ffff, 1'b1,
			16'h0001), 1'b0, NOTHING);
		add_row(mk(FUNC_POLL, 64'h0, 12'h0, 48'h0, 1'b0, 16'h0), 1'b1,
			'{1'b1, 64'hffff_ffff_ffff_ffff, 12'hfff, 48'h0});
		// zero address minus one wraps to all ones
		add_row(mk(FUNC_ADD, 64'h1, 12'h000, 48'h0, 1'b1, 16'hffff), 1'b0, NOTHING);
		add_row(mk(FUNC_POLL, 64'h0, 12'h0, 48'h0, 1'b0, 16'h0), 1'b1,
			'{1'b1, 64'h1, 12'h000, 48'hffff_ffff_ffff});
		// no address given: offset ignored, zero stored
		add_row(mk(FUNC_ADD, 64'h2, 12'h800, 48'h1234_5678_9abc, 1'b0, 16'h7fff), 1'b0, NOTHING);
		add_row(mk(FUNC_POLL, 64'h0, 12'h0, 48'h0, 1'b0, 16'h0), 1'b1,
			'{1'b1, 64'h2, 12'h800, 48'h0});
		// popped slot still blocks the same id
		add_row(mk(FUNC_ADD, 64'hffff_ffff_ffff_ffff, 12'h001, 48'h5, 1'b1, 16'h0), 1'b0, NOTHING);
		add_row(mk(FUNC_POLL, 64'h0, 12'h0, 48'h0, 1'b0, 16'h0), 1'b1, NOTHING);
		// own id in use is filtered
		add_row(mk(FUNC_ADD, 64'h0123_4567_89ab_cdef, 12'h010, 48'h6, 1'b1, 16'h0), 1'b0, NOTHING);
		add_row(mk(FUNC_POLL, 64'h0, 12'h0, 48'h0, 1'b0, 16'h0), 1'b1, NOTHING);
		// own id beyond the count passes; most negative offset
		add_row(mk(FUNC_ADD, 64'hfedc_ba98_7654_3210, 12'h0aa, 48'h8000, 1'b1, 16'h8000), 1'b0,
			NOTHING);
		add_row(mk(FUNC_POLL, 64'h0, 12'h0, 48'h0, 1'b0, 16'h0), 1'b1,
			'{1'b1, 64'hfedc_ba98_7654_3210, 12'h0aa, 48'h0});
		// two live entries, a live repeat, then drain past empty
		add_row(mk(FUNC_ADD, 64'h3, 12'h003, 48'h1, 1'b1, 16'h7fff), 1'b0, NOTHING);
		add_row(mk(FUNC_ADD, 64'h4, 12'h004, 48'ha5a5_a5a5_a5a5, 1'b1, 16'h1234), 1'b0, NOTHING);
		add_row(mk(FUNC_ADD, 64'h3, 12'h333, 48'h7, 1'b1, 16'h0), 1'b0, NOTHING);
		add_row(mk(FUNC_POLL, 64'h0, 12'h0, 48'h0, 1'b0, 16'h0), 1'b0, NOTHING);
		add_row(mk(FUNC_POLL, 64'h0, 12'h0, 48'h0, 1'b0, 16'h0), 1'b0, NOTHING);
		add_row(mk(FUNC_POLL, 64'h0, 12'h0, 48'h0, 1'b0, 16'h0), 1'b1, NOTHING);
		add_row(mk(FUNC_ADD, 64'h5a5a_5a5a_a5a5_a5a5, 12'h5a5, 48'h5555_aaaa_5555, 1'b1, 16'h0),
			1'b0, NOTHING);
		add_row(mk(FUNC_ADD, 64'h0000_0000_ffff_ffff, 12'ha5a, 48'haaaa_5555_aaaa, 1'b1, 16'hc000),
			1'b0, NOTHING);
		add_row(mk(FUNC_POLL, 64'hffff_ffff_ffff_ffff, 12'hfff, 48'hffff_ffff_ffff, 1'b1,
			16'hffff), 1'b0, NOTHING);
		add_row(mk(FUNC_POLL, 64'h0, 12'h0, 48'h0, 1'b0, 16'h0), 1'b0, NOTHING);

		while (dir_rows.size() != 0) begin
			row = dir_rows.pop_front();
			send_req(row.rq, row.typed, row.want);
		end

		// random part: one register setting per phase, filter count from off to saturated
		for (ph = 0; ph < int'(PHASES); ph++) begin
			drain(SETTLE);
			case (ph)
				0: load_regs(id_pool[0], id_pool[1], id_pool[2], id_pool[3], 3'd0);
				1: load_regs(id_pool[0], id_pool[1], id_pool[2], id_pool[3], 3'd1);
				2: load_regs(id_pool[4], id_pool[5], id_pool[6], id_pool[7], 3'd2);
				3: load_regs(id_pool[8], 64'h0, id_pool[9], id_pool[10], 3'd3);
				4: load_regs(64'hffff_ffff_ffff_ffff, 64'h0, id_pool[11], id_pool[12], 3'd4);
				default: load_regs(id_pool[13], id_pool[14], id_pool[15], id_pool[16], 3'd7);
			endcase
			calm = 1'b0;
			for (k = 0; k < int'(ITEMS_PER_PHASE); k++) begin
				// now and then switch idling off for a stretch
				if ($urandom_range(0, 59) == 0)
					calm = !calm;
				send_req(roll_request(), 1'b0, NOTHING);
			end
			calm = 1'b0;
		end

		drain(SETTLE);
		$display(
			"sent %0d requests, %0d settings: %0d stored, %0d own and %0d repeat drops",
			n_sent, PHASES + 1, n_stored, n_own_drop, n_dup_drop);
		$display("polls: %0d returned a stream, %0d found the history empty", n_popped, n_empty);
		if (mismatches == 0)
			$display("stream_discovery_dedup_fifo verification clean");
		else
			$display("stream_discovery_dedup_fifo verification failed");
		$finish;
	end

endmodule
